// File: sv/wlst_pkg.sv
// wlst_pkg: shared types and constants for the windowed latency statistics block
// holds the transaction structs, unit status struct, register indexes and widths
// no dependencies
package wlst_pkg;

   // default parameter values
   localparam int SAMPLE_BITS_DEF = 20;
   localparam int COUNT_BITS_DEF  = 16;
   localparam int FRAC_BITS_DEF   = 12;

   // fixed widths of the fields and state
   localparam int IN_SAMPLE_BITS  = 20;
   localparam int TIME_BITS       = 48;
   localparam int MEAN_BITS       = 32;
   localparam int SUM_BITS        = 64;
   localparam int ROOT_BITS       = 32;
   localparam int OUT_COUNT_BITS  = 16;
   localparam int OUT_SAMPLE_BITS = 20;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 4;

   localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = '1;

   // register indexes
   localparam logic [1:0] REG_REPORT_PERIOD  = 2'd0;
   localparam logic [1:0] REG_AVERAGE_PERIOD = 2'd1;
   localparam logic [1:0] REG_AVERAGE_ENABLE = 2'd2;

   localparam logic [CSR_DATA_BITS-1:0] PERIOD_RESET = 32'd1000000;

   typedef struct packed {
      logic [IN_SAMPLE_BITS-1:0] sample_us;
      logic [TIME_BITS-1:0]      end_time_us;
   } req_type;

   typedef struct packed {
      logic                       report_valid;
      logic [OUT_COUNT_BITS-1:0]  report_count;
      logic [MEAN_BITS-1:0]       report_mean;
      logic [ROOT_BITS-1:0]       report_std_dev;
      logic [OUT_SAMPLE_BITS-1:0] report_min;
      logic [OUT_SAMPLE_BITS-1:0] report_max;
      logic                       average_valid;
      logic [MEAN_BITS-1:0]       average_mean;
   } rsp_type;

   // status of a multi-cycle arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// File: sv/wlst_div.sv
// wlst_div: restoring divider, one quotient bit per cycle
// unsigned dividend and divisor, quotient valid when done pulses
// depends on wlst_pkg
module wlst_div import wlst_pkg::*; #(
   parameter int NUM_BITS = SUM_BITS,
   parameter int DEN_BITS = COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output unit_status_type     status,
   output logic [NUM_BITS-1:0] quot
);

   localparam int CW = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;
   logic                fits;

   assign trial = {rem_ff, num_ff[NUM_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CW'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         num_in = {num_ff[NUM_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = num_ff;

endmodule

// File: sv/wlst_mul.sv
// wlst_mul: bit-serial shift-add multiplier, multiplier bits taken msb first
// product saturates at the all-ones value of SUM_BITS
// depends on wlst_pkg
module wlst_mul import wlst_pkg::*; #(
   parameter int WIDTH = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [WIDTH-1:0]    a,
   input  logic [WIDTH-1:0]    b,
   output unit_status_type     status,
   output logic [SUM_BITS-1:0] prod
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]    a_ff, a_in;
   logic [WIDTH-1:0]    b_ff, b_in;
   logic [SUM_BITS-1:0] acc_ff, acc_in;
   logic                sat_ff, sat_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [SUM_BITS+1:0] step_sum;

   // acc * 2 + (bit ? a : 0), with two guard bits to spot overflow
   assign step_sum = {1'b0, acc_ff, 1'b0}
                   + (b_ff[WIDTH-1] ? (SUM_BITS+2)'(a_ff) : '0);

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         sat_in  = 1'b0;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = step_sum[SUM_BITS-1:0];
         sat_in = sat_ff | (|step_sum[SUM_BITS+1:SUM_BITS]);
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      sat_ff <= sat_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign prod        = sat_ff ? '1 : acc_ff;

endmodule

// File: sv/wlst_sqrt.sv
// wlst_sqrt: digit-by-digit integer square root, one root bit per cycle
// radicand of 2*ROOT_BITS bits consumed two bits at a time
// depends on wlst_pkg
module wlst_sqrt import wlst_pkg::*; #(
   parameter int RBITS = ROOT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2*RBITS-1:0]   rad,
   output unit_status_type      status,
   output logic [RBITS-1:0]     root
);

   localparam int CW = $clog2(RBITS + 1);

   logic [2*RBITS-1:0] rad_ff, rad_in;
   logic [RBITS-1:0]   rem_ff, rem_in;
   logic [RBITS-1:0]   root_ff, root_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [RBITS+1:0]   rem_sh;
   logic [RBITS+1:0]   trial;
   logic [RBITS+1:0]   diff;
   logic               fits;

   assign rem_sh = {rem_ff, rad_ff[2*RBITS-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = rem_sh >= trial;
   assign diff   = rem_sh - trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(RBITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         // remainder stays at most 2*root, so its top bits are zero here
         rem_in  = fits ? diff[RBITS-1:0] : rem_sh[RBITS-1:0];
         root_in = {root_ff[RBITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

// File: sv/windowed_latency_statistics.sv
// windowed_latency_statistics: top level, sequencer, state and register port
// uses wlst_pkg, wlst_div, wlst_mul and wlst_sqrt
//
// usage
// - req channel: one transaction per latency sample (sample_us, end_time_us)
// - rsp channel: exactly one transaction per sample, carrying the report and
//   secondary-average figures; the valid flags inside say which are live
// - apb port: report_period at 0x0, average_period at 0x4, average_enable
//   at 0x8; the user must write them only while the block is idle, the block does not enforce it
// - a sample is worked one at a time; req_stall stays high from acceptance
//   until its result is loaded into the output register
// - a sample that closes no window waits on the shared divider for its mean
//   update; a growing deviation sum adds a multiplier pass, the secondary
//   window another pass through the shared welford steps, and a report a
//   divider pass for the deviation plus a square-root pass
// - the next sample is accepted only once the block has loaded the result
//   of the last one and returned to idle
// - a result waiting under rsp_stall does not stop the next sample from
//   being accepted; only the load of the following result waits for it
// - reset: periods take their reset value, average_enable clears, statistics clear and
//   both windows are closed until the first sample opens them
module windowed_latency_statistics import wlst_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // sample transactions
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   // result transactions
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   // magnitude of a difference between a scaled sample and a mean
   localparam int MAG_BITS = (SAMPLE_BITS + FRAC_BITS > MEAN_BITS) ?
                             SAMPLE_BITS + FRAC_BITS : MEAN_BITS;
   localparam int SW       = MAG_BITS + 2;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_OPEN   = 4'd1;
   localparam logic [3:0] ST_SETUP  = 4'd2;
   localparam logic [3:0] ST_KICK   = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_MEAN   = 4'd5;
   localparam logic [3:0] ST_ERR    = 4'd6;
   localparam logic [3:0] ST_MUL    = 4'd7;
   localparam logic [3:0] ST_AVG    = 4'd8;
   localparam logic [3:0] ST_ACHECK = 4'd9;
   localparam logic [3:0] ST_RCHECK = 4'd10;
   localparam logic [3:0] ST_SDIV   = 4'd11;
   localparam logic [3:0] ST_SQRT   = 4'd12;
   localparam logic [3:0] ST_DONE   = 4'd13;

   // which window the shared welford steps work on
   localparam logic PATH_REPORT  = 1'b0;
   localparam logic PATH_AVERAGE = 1'b1;

   logic [3:0]             state_ff, state_in;
   logic [SAMPLE_BITS-1:0] s_ff, s_in;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic                   open_ff, open_in;
   logic                   path_ff, path_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [MEAN_BITS-1:0]   mean_ff, mean_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [TIME_BITS-1:0]   rep_start_ff, rep_start_in;
   logic [COUNT_BITS-1:0]  avg_cnt_ff, avg_cnt_in;
   logic [MEAN_BITS-1:0]   avg_mean_ff, avg_mean_in;
   logic [TIME_BITS-1:0]   avg_start_ff, avg_start_in;
   logic signed [SW-1:0]   delta_ff, delta_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CSR_DATA_BITS-1:0] rep_period_ff, avg_period_ff;
   logic                   avg_en_ff;

   // arithmetic units
   unit_status_type        div_st, mul_st, sqrt_st;
   logic                   div_start, mul_start, sqrt_start;
   logic [SUM_BITS-1:0]    div_num, div_quot, mul_prod;
   logic [COUNT_BITS-1:0]  div_den;
   logic [ROOT_BITS-1:0]   sqrt_root;

   // datapath
   logic signed [SW-1:0]   s_fix, mean_ext, delta_new, q_s, nm_raw;
   logic [MEAN_BITS-1:0]   mean_base, nm_clamp;
   logic [COUNT_BITS-1:0]  cnt_base, cnt_next;
   logic [MAG_BITS-1:0]    delta_mag, err_mag;
   logic                   same_sign;
   logic [SUM_BITS:0]      sum_wide;
   logic                   rep_elapsed, avg_elapsed;
   logic                   req_take, cfg_write;

   assign req_stall = state_ff != ST_IDLE;
   assign req_take  = req_valid && !req_stall;

   // welford datapath, shared by both windows
   assign s_fix     = signed'(SW'(s_ff) << FRAC_BITS);
   assign mean_base = (path_ff == PATH_AVERAGE) ? avg_mean_ff : mean_ff;
   assign mean_ext  = signed'(SW'(mean_base));
   assign delta_new = s_fix - mean_ext;
   assign cnt_base  = (path_ff == PATH_AVERAGE) ? avg_cnt_ff : cnt_ff;
   assign cnt_next  = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + 1'b1;
   assign delta_mag = MAG_BITS'(delta_ff[SW-1] ? -delta_ff : delta_ff);
   assign err_mag   = MAG_BITS'(delta_new[SW-1] ? -delta_new : delta_new);

   // quotient magnitude never exceeds |delta|, sign follows delta
   assign q_s    = signed'(SW'(div_quot[MAG_BITS-1:0]));
   assign nm_raw = mean_ext + (delta_ff[SW-1] ? -q_s : q_s);

   always_comb begin
      if (nm_raw[SW-1]) begin
         nm_clamp = '0;
      end else if (|nm_raw[SW-2:MEAN_BITS]) begin
         nm_clamp = '1;
      end else begin
         nm_clamp = nm_raw[MEAN_BITS-1:0];
      end
   end

   // in ST_ERR delta_new holds the error against the updated mean
   assign same_sign = (!delta_ff[SW-1] && (delta_ff != '0) &&
                       !delta_new[SW-1] && (delta_new != '0)) ||
                      (delta_ff[SW-1] && delta_new[SW-1]);

   assign sum_wide    = {1'b0, sum_ff} + {1'b0, mul_prod};
   assign rep_elapsed = (now_ff - rep_start_ff) > TIME_BITS'(rep_period_ff);
   assign avg_elapsed = (now_ff - avg_start_ff) > TIME_BITS'(avg_period_ff);

   // unit control
   assign div_start  = (state_ff == ST_KICK) ||
                       ((state_ff == ST_RCHECK) && rep_elapsed && (cnt_ff != '0));
   assign div_num    = (state_ff == ST_KICK) ? SUM_BITS'(delta_mag) : sum_ff;
   assign div_den    = (state_ff == ST_KICK) ? cnt_base : cnt_ff;
   assign mul_start  = (state_ff == ST_ERR) && same_sign;
   assign sqrt_start = (state_ff == ST_SDIV) && div_st.done;

   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      now_in       = now_ff;
      open_in      = open_ff;
      path_in      = path_ff;
      cnt_in       = cnt_ff;
      mean_in      = mean_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rep_start_in = rep_start_ff;
      avg_cnt_in   = avg_cnt_ff;
      avg_mean_in  = avg_mean_ff;
      avg_start_in = avg_start_ff;
      delta_in     = delta_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      // output register empties when its transaction is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               s_in     = SAMPLE_BITS'(req_data.sample_us);
               now_in   = req_data.end_time_us;
               res_in   = '0;
               path_in  = PATH_REPORT;
               state_in = ST_OPEN;
            end
         end
         ST_OPEN: begin
            // first sample opens both windows at the start of its lap
            if (!open_ff) begin
               rep_start_in = now_ff - TIME_BITS'(s_ff);
               avg_start_in = now_ff - TIME_BITS'(s_ff);
               open_in      = 1'b1;
            end
            if (s_ff < min_ff) begin
               min_in = s_ff;
            end
            if (s_ff > max_ff) begin
               max_in = s_ff;
            end
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (path_ff == PATH_AVERAGE) begin
               avg_cnt_in = cnt_next;
            end else begin
               cnt_in = cnt_next;
            end
            delta_in = delta_new;
            state_in = ST_KICK;
         end
         ST_KICK: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_st.done) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (path_ff == PATH_AVERAGE) begin
               avg_mean_in = nm_clamp;
               state_in    = ST_ACHECK;
            end else begin
               mean_in  = nm_clamp;
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            state_in = same_sign ? ST_MUL : ST_AVG;
         end
         ST_MUL: begin
            if (mul_st.done) begin
               sum_in   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            if (avg_en_ff) begin
               path_in  = PATH_AVERAGE;
               state_in = ST_SETUP;
            end else begin
               state_in = ST_RCHECK;
            end
         end
         ST_ACHECK: begin
            if (avg_elapsed) begin
               res_in.average_valid = 1'b1;
               res_in.average_mean  = avg_mean_ff;
               avg_start_in         = now_ff;
               avg_cnt_in           = '0;
               avg_mean_in          = '0;
            end
            state_in = ST_RCHECK;
         end
         ST_RCHECK: begin
            if (rep_elapsed) begin
               res_in.report_valid = 1'b1;
               res_in.report_count = (32'(cnt_ff) > 32'(OUT_COUNT_MAX)) ?
                                     OUT_COUNT_MAX : OUT_COUNT_BITS'(cnt_ff);
               res_in.report_mean  = mean_ff;
               res_in.report_min   = OUT_SAMPLE_BITS'(min_ff);
               res_in.report_max   = OUT_SAMPLE_BITS'(max_ff);
               // divider has latched sum and count on this edge
               rep_start_in = now_ff;
               cnt_in       = '0;
               mean_in      = '0;
               sum_in       = '0;
               min_in       = '1;
               max_in       = '0;
               state_in     = (cnt_ff != '0) ? ST_SDIV : ST_DONE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SDIV: begin
            if (div_st.done) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_st.done) begin
               res_in.report_std_dev = sqrt_root;
               state_in              = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      now_ff      <= now_in;
      path_ff     <= path_in;
      delta_ff    <= delta_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= 1'b0;
         cnt_ff       <= '0;
         mean_ff      <= '0;
         sum_ff       <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         rep_start_ff <= '0;
         avg_cnt_ff   <= '0;
         avg_mean_ff  <= '0;
         avg_start_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         cnt_ff       <= cnt_in;
         mean_ff      <= mean_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rep_start_ff <= rep_start_in;
         avg_cnt_ff   <= avg_cnt_in;
         avg_mean_ff  <= avg_mean_in;
         avg_start_ff <= avg_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // register port, word addressed
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_period_ff <= PERIOD_RESET;
         avg_period_ff <= PERIOD_RESET;
         avg_en_ff     <= 1'b0;
      end else if (cfg_write) begin
         unique case (paddr[3:2])
            REG_REPORT_PERIOD:  rep_period_ff <= pwdata;
            REG_AVERAGE_PERIOD: avg_period_ff <= pwdata;
            REG_AVERAGE_ENABLE: avg_en_ff     <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_REPORT_PERIOD:  prdata = rep_period_ff;
         REG_AVERAGE_PERIOD: prdata = avg_period_ff;
         REG_AVERAGE_ENABLE: prdata = CSR_DATA_BITS'(avg_en_ff);
         default:            prdata = '0;
      endcase
   end

   wlst_div #(
      .NUM_BITS (SUM_BITS),
      .DEN_BITS (COUNT_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_st),
      .quot   (div_quot)
   );

   wlst_mul #(
      .WIDTH (MAG_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (delta_mag),
      .b      (err_mag),
      .status (mul_st),
      .prod   (mul_prod)
   );

   wlst_sqrt #(
      .RBITS (ROOT_BITS)
   ) u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sqrt_start),
      .rad    (div_quot),
      .status (sqrt_st),
      .root   (sqrt_root)
   );

   // units are only started when idle
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_st.busy)
      else $error("divider started while busy");

   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_st.busy)
      else $error("multiplier started while busy");

   a_sqrt_start_idle: assert property (@(posedge clock) disable iff (reset)
      sqrt_start |-> !sqrt_st.busy)
      else $error("square root started while busy");

   // windows open only through an accepted sample
   a_open_on_sample: assert property (@(posedge clock) disable iff (reset)
      $rose(open_ff) |-> $past(state_ff == ST_OPEN))
      else $error("windows opened without a sample");

   // an empty report carries no figures
   a_report_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.report_valid) |->
      (rsp_data_ff.report_count == '0 && rsp_data_ff.report_mean == '0 &&
       rsp_data_ff.report_std_dev == '0))
      else $error("report fields set without report_valid");

endmodule
